### hw/rtl/kdef_pkg.sv
// shared types, constants and helpers for the key debounce event fifo
package kdef_pkg;

    // field widths
    localparam int CODE_W      = 4;
    localparam int PIN_W       = 5;
    localparam int FILTER_W    = 7;
    localparam int LONG_W      = 16;
    localparam int REPEAT_W    = 8;
    localparam int DEBOUNCE_W  = 8;
    localparam int KEY_NUM_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // parameter defaults
    localparam int NUM_KEYS_DEF   = 5;
    localparam int FIFO_DEPTH_DEF = 16;

    // configuration reset values
    localparam logic [FILTER_W-1:0] FILTER_TIME_RST   = FILTER_W'(5);
    localparam logic [LONG_W-1:0]   LONG_TIME_RST     = LONG_W'(100);
    localparam logic [REPEAT_W-1:0] REPEAT_PERIOD_RST = '0;
    localparam logic [PIN_W-1:0]    ACTIVE_LEVELS_RST = '0;

    // debounce counter starts at half the reset filter time
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(5 / 2);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_TIME   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_TIME     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_PERIOD = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEVELS = 2'd3;

    // request commands
    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // event kinds, added to three times the key number
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;
    localparam logic [1:0] EV_LONG    = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PUSH_SECOND,
        ST_POP,
        ST_DONE
    } kdef_state_t;

    // timing configuration seen by the key unit
    typedef struct packed {
        logic [FILTER_W-1:0] filter_time;
        logic [LONG_W-1:0]   long_time;
        logic [REPEAT_W-1:0] repeat_period;
    } kdef_cfg_t;

    // up to two fifo writes raised by one key in one tick, in order
    typedef struct packed {
        logic              first_valid;
        logic [CODE_W-1:0] first_code;
        logic              second_valid;
        logic [CODE_W-1:0] second_code;
    } kdef_push_t;

    // event code 3*key + kind, kept to four bits
    function automatic logic [CODE_W-1:0] event_code(input logic [KEY_NUM_W-1:0] key,
                                                     input logic [1:0] kind);
        logic [KEY_NUM_W+2:0] sum;
        sum = (KEY_NUM_W + 3)'(key) * (KEY_NUM_W + 3)'(3) + (KEY_NUM_W + 3)'(kind);
        return sum[CODE_W-1:0];
    endfunction

endpackage

### hw/rtl/kdef_req_if.sv
// request channel: command and pin sample
interface kdef_req_if
    import kdef_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             command;
    logic [PIN_W-1:0] pin_levels;

    modport source (output valid, output command, output pin_levels, input ready);
    modport sink (input valid, input command, input pin_levels, output ready);
endinterface

### hw/rtl/kdef_rsp_if.sv
// response channel: popped key code
interface kdef_rsp_if
    import kdef_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] key_code;
    logic              code_valid;

    modport source (output valid, output key_code, output code_valid, input ready);
    modport sink (input valid, input key_code, input code_valid, output ready);
endinterface

### hw/rtl/kdef_key_unit.sv
// shared per-key debounce, long-press and repeat unit with the key state store
module kdef_key_unit
    import kdef_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic [(NUM_KEYS > 1 ? $clog2(NUM_KEYS) : 1)-1:0] key_idx,
    input  logic                                       key_down,
    input  logic                                       update,
    input  kdef_cfg_t                                  cfg,
    output kdef_push_t                                 push
);
    logic [DEBOUNCE_W-1:0] debounce_reg [NUM_KEYS];
    logic                  pressed_reg  [NUM_KEYS];
    logic [LONG_W-1:0]     long_reg     [NUM_KEYS];
    logic [REPEAT_W-1:0]   repeat_reg   [NUM_KEYS];

    logic [DEBOUNCE_W-1:0] debounce_next;
    logic                  pressed_next;
    logic [LONG_W-1:0]     long_next;
    logic [REPEAT_W-1:0]   repeat_next;

    logic [DEBOUNCE_W-1:0] dc;
    logic [LONG_W-1:0]     lc;
    logic [REPEAT_W-1:0]   rc;
    logic [REPEAT_W-1:0]   rc_inc;
    logic [DEBOUNCE_W-1:0] ft;
    logic [DEBOUNCE_W-1:0] ft_twice;
    logic                  ev_press;
    logic                  ev_release;
    logic                  ev_long;
    logic                  ev_repeat;
    logic [KEY_NUM_W-1:0]  key_num;

    assign dc       = debounce_reg[key_idx];
    assign lc       = long_reg[key_idx];
    assign rc       = repeat_reg[key_idx];
    assign rc_inc   = rc + REPEAT_W'(1);
    assign ft       = DEBOUNCE_W'(cfg.filter_time);
    assign ft_twice = {cfg.filter_time, 1'b0};
    assign key_num  = KEY_NUM_W'(key_idx);

    // next state of the selected key and the events it raises
    always_comb
    begin
        debounce_next = dc;
        pressed_next  = pressed_reg[key_idx];
        long_next     = lc;
        repeat_next   = rc;
        ev_press      = 1'b0;
        ev_release    = 1'b0;
        ev_long       = 1'b0;
        ev_repeat     = 1'b0;
        if (key_down)
        begin
            if (dc < ft)
            begin
                debounce_next = ft;
            end
            else if (dc < ft_twice)
            begin
                debounce_next = dc + DEBOUNCE_W'(1);
            end
            else
            begin
                if (!pressed_reg[key_idx])
                begin
                    pressed_next = 1'b1;
                    ev_press     = 1'b1;
                end
                if (cfg.long_time != '0)
                begin
                    if (lc < cfg.long_time)
                    begin
                        long_next = lc + LONG_W'(1);
                        ev_long   = (long_next == cfg.long_time);
                    end
                    else if (cfg.repeat_period != '0)
                    begin
                        if (rc_inc >= cfg.repeat_period)
                        begin
                            repeat_next = '0;
                            ev_repeat   = 1'b1;
                        end
                        else
                        begin
                            repeat_next = rc_inc;
                        end
                    end
                end
            end
        end
        else
        begin
            if (dc > ft)
            begin
                debounce_next = ft;
            end
            else if (dc != '0)
            begin
                debounce_next = dc - DEBOUNCE_W'(1);
            end
            else if (pressed_reg[key_idx])
            begin
                pressed_next = 1'b0;
                ev_release   = 1'b1;
            end
            long_next   = '0;
            repeat_next = '0;
        end
    end

    // pack the events in push order, press or release first
    always_comb
    begin
        push.first_valid  = ev_press | ev_release | ev_long | ev_repeat;
        push.second_valid = ev_press & (ev_long | ev_repeat);
        push.second_code  = ev_long ? event_code(key_num, EV_LONG)
                                    : event_code(key_num, EV_PRESS);
        if (ev_release)
        begin
            push.first_code = event_code(key_num, EV_RELEASE);
        end
        else if (ev_long && !ev_press)
        begin
            push.first_code = event_code(key_num, EV_LONG);
        end
        else
        begin
            push.first_code = event_code(key_num, EV_PRESS);
        end
    end

    // key state store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                debounce_reg[i] <= DEBOUNCE_RST;
                pressed_reg[i]  <= 1'b0;
                long_reg[i]     <= '0;
                repeat_reg[i]   <= '0;
            end
        end
        else if (update)
        begin
            debounce_reg[key_idx] <= debounce_next;
            pressed_reg[key_idx]  <= pressed_next;
            long_reg[key_idx]     <= long_next;
            repeat_reg[key_idx]   <= repeat_next;
        end
    end

endmodule

### hw/rtl/kdef_fifo.sv
// ring buffer of event codes with no full check
module kdef_fifo
    import kdef_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [CODE_W-1:0] wr_code,
    input  logic              rd_en,
    output logic [CODE_W-1:0] rd_code,
    output logic              empty
);
    localparam int PTR_W = $clog2(FIFO_DEPTH);

    logic [CODE_W-1:0] mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CODE_W-1:0] rd_code_reg;

    assign empty   = (rd_ptr_reg == wr_ptr_reg);
    assign rd_code = rd_code_reg;

    // pointers wrap at the buffer depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // storage write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_code;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_code_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

### hw/rtl/key_debounce_event_fifo.sv
// Key debounce and event fifo: a scan tick steps the shared key unit through each key in turn
// in ST_EVAL, with an extra ST_PUSH_SECOND for each key that raises two events in the same tick,
// then ST_DONE loads the result. A pop request reads the fifo in ST_POP, then loads the result
// onto the response channel in ST_DONE. One request at a time, taken in the cycle after the
// last result load; the load waits while the previous result is still not taken.
// Reset clears configuration, key state and fifo pointers at once; fifo contents undefined.
module key_debounce_event_fifo
    import kdef_pkg::*;
#(
    parameter int NUM_KEYS   = NUM_KEYS_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    kdef_req_if.sink               req,
    kdef_rsp_if.source             rsp,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);
    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    kdef_state_t          state_reg;
    kdef_state_t          state_next;
    logic [FILTER_W-1:0]  filter_time_reg;
    logic [LONG_W-1:0]    long_time_reg;
    logic [REPEAT_W-1:0]  repeat_period_reg;
    logic [PIN_W-1:0]     active_levels_reg;
    logic [NUM_KEYS-1:0]  down_mask_reg;
    logic [IDX_W-1:0]     key_idx_reg;
    logic [CODE_W-1:0]    second_code_reg;
    logic                 pop_hit_reg;
    logic                 rsp_valid_reg;
    logic [CODE_W-1:0]    rsp_code_reg;
    logic                 rsp_flag_reg;

    kdef_cfg_t            cfg;
    kdef_push_t           push;
    logic [NUM_KEYS-1:0]  match;
    logic                 req_fire;
    logic                 last_key;
    logic                 key_update;
    logic                 fifo_wr;
    logic [CODE_W-1:0]    fifo_wr_code;
    logic                 fifo_rd;
    logic [CODE_W-1:0]    fifo_rd_code;
    logic                 fifo_empty;
    logic                 rsp_load;

    assign cfg.filter_time   = filter_time_reg;
    assign cfg.long_time     = long_time_reg;
    assign cfg.repeat_period = repeat_period_reg;

    // pins at their active level; a key is down only when alone
    assign match    = ~(req.pin_levels[NUM_KEYS-1:0] ^ active_levels_reg[NUM_KEYS-1:0]);
    assign req_fire = req.valid && req.ready;
    assign last_key = (key_idx_reg == IDX_W'(NUM_KEYS - 1));

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.key_code   = rsp_code_reg;
    assign rsp.code_valid = rsp_flag_reg;

    kdef_key_unit #(
        .NUM_KEYS (NUM_KEYS)
    ) u_key_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_idx  (key_idx_reg),
        .key_down (down_mask_reg[key_idx_reg]),
        .update   (key_update),
        .cfg      (cfg),
        .push     (push)
    );

    kdef_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fifo_wr),
        .wr_code (fifo_wr_code),
        .rd_en   (fifo_rd),
        .rd_code (fifo_rd_code),
        .empty   (fifo_empty)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = (req.command == CMD_POP) ? ST_POP : ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (push.second_valid)
                begin
                    state_next = ST_PUSH_SECOND;
                end
                else if (last_key)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PUSH_SECOND:
            begin
                state_next = last_key ? ST_DONE : ST_EVAL;
            end
            ST_POP:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req.ready    = 1'b0;
        key_update   = 1'b0;
        fifo_wr      = 1'b0;
        fifo_wr_code = push.first_code;
        fifo_rd      = 1'b0;
        rsp_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_EVAL:
            begin
                key_update = 1'b1;
                fifo_wr    = push.first_valid;
            end
            ST_PUSH_SECOND:
            begin
                fifo_wr      = 1'b1;
                fifo_wr_code = second_code_reg;
            end
            ST_POP:
            begin
                fifo_rd = 1'b1;
            end
            ST_DONE:
            begin
                rsp_load = !rsp_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // state and sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_idx_reg   <= '0;
            down_mask_reg <= '0;
            pop_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_fire)
            begin
                key_idx_reg   <= '0;
                down_mask_reg <= $onehot(match) ? match : '0;
                pop_hit_reg   <= 1'b0;
            end
            if (state_reg == ST_POP)
            begin
                pop_hit_reg <= !fifo_empty;
            end
            // step to the next key once its pushes are written
            if ((state_reg == ST_EVAL && !push.second_valid && !last_key)
                || (state_reg == ST_PUSH_SECOND && !last_key))
            begin
                key_idx_reg <= key_idx_reg + IDX_W'(1);
            end
        end
    end

    // second pending code of the current key
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EVAL)
        begin
            second_code_reg <= push.second_code;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_time_reg   <= FILTER_TIME_RST;
            long_time_reg     <= LONG_TIME_RST;
            repeat_period_reg <= REPEAT_PERIOD_RST;
            active_levels_reg <= ACTIVE_LEVELS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FILTER_TIME:   filter_time_reg   <= cfg_data[FILTER_W-1:0];
                REG_LONG_TIME:     long_time_reg     <= cfg_data[LONG_W-1:0];
                REG_REPEAT_PERIOD: repeat_period_reg <= cfg_data[REPEAT_W-1:0];
                REG_ACTIVE_LEVELS: active_levels_reg <= cfg_data[PIN_W-1:0];
                default:           filter_time_reg   <= filter_time_reg;
            endcase
        end
    end

    // response output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_code_reg <= pop_hit_reg ? fifo_rd_code : '0;
            rsp_flag_reg <= pop_hit_reg;
        end
    end

endmodule
